/* rtl/core/kne_pkg.sv */
`default_nettype none

package kne_pkg;

  // Widths of the item fields.
  localparam int unsigned KEY_W    = 5;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CURSOR_W = 2;
  localparam int unsigned FLAGS_W  = 4;
  localparam int unsigned TARGET_W = 2;
  localparam int unsigned TENTHS_W = 14;
  localparam int unsigned VALUE_W  = 10;
  localparam int unsigned NDIGITS  = 3;

  // Key codes with a fixed meaning.
  localparam logic [KEY_W-1:0] KEY_NONE         = 5'd0;
  localparam logic [KEY_W-1:0] KEY_FLAG_LAST    = 5'd4;
  localparam logic [KEY_W-1:0] KEY_TARGET_FIRST = 5'd5;
  localparam logic [KEY_W-1:0] KEY_TARGET_LAST  = 5'd8;
  localparam logic [KEY_W-1:0] KEY_POINT        = 5'd4;
  localparam logic [KEY_W-1:0] KEY_CLEAR        = 5'd8;
  localparam logic [KEY_W-1:0] KEY_CANCEL       = 5'd12;
  localparam logic [KEY_W-1:0] KEY_LEFT         = 5'd13;
  localparam logic [KEY_W-1:0] KEY_RIGHT        = 5'd15;
  localparam logic [KEY_W-1:0] KEY_COMMIT       = 5'd16;

  // Cursor limits.
  localparam logic [CURSOR_W-1:0] CURSOR_FIRST = 2'd0;
  localparam logic [CURSOR_W-1:0] CURSOR_MID   = 2'd1;
  localparam logic [CURSOR_W-1:0] CURSOR_LAST  = 2'd2;

  // Architectural state of the entry controller.
  typedef struct packed {
    logic                             entry;
    logic [CURSOR_W-1:0]              cursor;
    logic [NDIGITS-1:0][DIGIT_W-1:0]  digits;
    logic                             point;
    logic [TARGET_W-1:0]              target;
    logic [FLAGS_W-1:0]               flags;
  } kne_state_t;

  // One result item.
  typedef struct packed {
    logic                   in_entry;
    logic [DIGIT_W-1:0]     digit_hundreds;
    logic [DIGIT_W-1:0]     digit_tens;
    logic [DIGIT_W-1:0]     digit_units;
    logic                   point_on;
    logic [CURSOR_W-1:0]    cursor_pos;
    logic [FLAGS_W-1:0]     feature_flags;
    logic                   commit_valid;
    logic [TARGET_W-1:0]    commit_target;
    logic [TENTHS_W-1:0]    commit_tenths;
  } kne_result_t;

  // Digit lookup for entry mode: the top bit marks a digit key.
  function automatic logic [DIGIT_W:0] digit_of_key(input logic [KEY_W-1:0] key);
    logic [DIGIT_W:0] d;
    begin
      case (key)
        5'd1:    d = {1'b1, 4'd1};
        5'd2:    d = {1'b1, 4'd2};
        5'd3:    d = {1'b1, 4'd3};
        5'd5:    d = {1'b1, 4'd4};
        5'd6:    d = {1'b1, 4'd5};
        5'd7:    d = {1'b1, 4'd6};
        5'd9:    d = {1'b1, 4'd7};
        5'd10:   d = {1'b1, 4'd8};
        5'd11:   d = {1'b1, 4'd9};
        5'd14:   d = {1'b1, 4'd0};
        default: d = {1'b0, 4'd0};
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/core/kne_step.sv */
`default_nettype none

// Next-state and result logic for one key press.
module kne_step (
  input  wire logic [kne_pkg::KEY_W-1:0] key,
  input  wire kne_pkg::kne_state_t       state,
  output kne_pkg::kne_state_t            state_next,
  output kne_pkg::kne_result_t           result
);

  logic [kne_pkg::DIGIT_W:0]     dig;
  logic [kne_pkg::VALUE_W-1:0]   value;
  logic [kne_pkg::TENTHS_W-1:0]  tenths;
  logic                          commit;
  logic [1:0]                    key_low;

  assign dig     = kne_pkg::digit_of_key(key);
  assign key_low = key[1:0] - 2'd1;

  // Buffered value as an integer, then scaled to tenths by the point.
  assign value = kne_pkg::VALUE_W'(state.digits[0]) * 10'd100
               + kne_pkg::VALUE_W'(state.digits[1]) * 10'd10
               + kne_pkg::VALUE_W'(state.digits[2]);
  assign tenths = state.point ? kne_pkg::TENTHS_W'(value)
                              : kne_pkg::TENTHS_W'(value) * 14'd10;

  // State update.
  always_comb begin
    state_next = state;
    commit     = 1'b0;
    if (key != kne_pkg::KEY_NONE && key <= kne_pkg::KEY_COMMIT) begin
      if (!state.entry) begin
        if (key <= kne_pkg::KEY_FLAG_LAST) begin
          state_next.flags = state.flags ^ (4'b0001 << key_low);
        end else if (key inside {[kne_pkg::KEY_TARGET_FIRST : kne_pkg::KEY_TARGET_LAST]}) begin
          state_next.cursor = kne_pkg::CURSOR_FIRST;
          state_next.digits = '0;
          state_next.point  = 1'b0;
          state_next.target = key_low;
          state_next.entry  = 1'b1;
        end
      end else if (dig[kne_pkg::DIGIT_W]) begin
        case (state.cursor)
          kne_pkg::CURSOR_MID:  state_next.digits[1] = dig[kne_pkg::DIGIT_W-1:0];
          kne_pkg::CURSOR_LAST: state_next.digits[2] = dig[kne_pkg::DIGIT_W-1:0];
          default:              state_next.digits[0] = dig[kne_pkg::DIGIT_W-1:0];
        endcase
      end else begin
        case (key)
          kne_pkg::KEY_POINT: state_next.point = ~state.point;
          kne_pkg::KEY_CLEAR: begin
            state_next.cursor = kne_pkg::CURSOR_FIRST;
            state_next.digits = '0;
            state_next.point  = 1'b0;
          end
          kne_pkg::KEY_CANCEL, kne_pkg::KEY_COMMIT: begin
            state_next.cursor = kne_pkg::CURSOR_FIRST;
            state_next.digits = '0;
            state_next.point  = 1'b0;
            state_next.entry  = 1'b0;
            commit            = (key == kne_pkg::KEY_COMMIT);
          end
          kne_pkg::KEY_LEFT: begin
            if (state.cursor != kne_pkg::CURSOR_FIRST) begin
              state_next.cursor = state.cursor - 2'd1;
            end
          end
          kne_pkg::KEY_RIGHT: begin
            if (state.cursor < kne_pkg::CURSOR_LAST) begin
              state_next.cursor = state.cursor + 2'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result shows the state after the key and any commit.
  always_comb begin
    result.in_entry       = state_next.entry;
    result.digit_hundreds = state_next.digits[0];
    result.digit_tens     = state_next.digits[1];
    result.digit_units    = state_next.digits[2];
    result.point_on       = state_next.point;
    result.cursor_pos     = state_next.cursor;
    result.feature_flags  = state_next.flags;
    result.commit_valid   = commit;
    result.commit_target  = commit ? state.target : '0;
    result.commit_tenths  = commit ? tenths : '0;
  end

endmodule

`default_nettype wire

/* rtl/core/keypad_number_entry_unit.sv */
// Each key's result is registered in the output register or the skid register.
// Throughput: one key per cycle unless in_stall is high; the state update and the
// result are one pass of logic from the state registers to the output register.
// A two-entry output stage (output register plus skid register) keeps input open
// for one more key while a result is stalled.
// Reset (rst, synchronous) clears the mode, buffer, target, flags and output valids.
`default_nettype none

module keypad_number_entry_unit (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [kne_pkg::KEY_W-1:0]          key_code,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    in_entry,
  output logic [kne_pkg::DIGIT_W-1:0]             digit_hundreds,
  output logic [kne_pkg::DIGIT_W-1:0]             digit_tens,
  output logic [kne_pkg::DIGIT_W-1:0]             digit_units,
  output logic                                    point_on,
  output logic [kne_pkg::CURSOR_W-1:0]            cursor_pos,
  output logic [kne_pkg::FLAGS_W-1:0]             feature_flags,
  output logic                                    commit_valid,
  output logic [kne_pkg::TARGET_W-1:0]            commit_target,
  output logic [kne_pkg::TENTHS_W-1:0]            commit_tenths
);

  kne_pkg::kne_state_t  state;
  kne_pkg::kne_state_t  state_next;
  kne_pkg::kne_result_t result_new;
  kne_pkg::kne_result_t out_reg;
  kne_pkg::kne_result_t skid;
  logic                 skid_valid;
  logic                 in_take;
  logic                 out_take;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !skid_valid;
  assign out_take = out_valid && !out_stall;

  kne_step u_step (
    .key        (key_code),
    .state      (state),
    .state_next (state_next),
    .result     (result_new)
  );

  // State registers advance on every input transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // Output register with a skid register behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_take) begin
      if (skid_valid) begin
        out_reg    <= skid;
        skid_valid <= 1'b0;
      end else if (in_take) begin
        out_reg <= result_new;
      end else begin
        out_valid <= 1'b0;
      end
    end else if (!out_valid) begin
      if (in_take) begin
        out_reg   <= result_new;
        out_valid <= 1'b1;
      end
    end else if (in_take) begin
      skid       <= result_new;
      skid_valid <= 1'b1;
    end
  end

  assign in_entry       = out_reg.in_entry;
  assign digit_hundreds = out_reg.digit_hundreds;
  assign digit_tens     = out_reg.digit_tens;
  assign digit_units    = out_reg.digit_units;
  assign point_on       = out_reg.point_on;
  assign cursor_pos     = out_reg.cursor_pos;
  assign feature_flags  = out_reg.feature_flags;
  assign commit_valid   = out_reg.commit_valid;
  assign commit_target  = out_reg.commit_target;
  assign commit_tenths  = out_reg.commit_tenths;

  // The skid register is only ever filled behind a full output register.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid register holds a result with the output register empty");

  // A transfer into a stalled output stage must land in the skid register.
  a_stall_fills_skid: assert property (@(posedge clk) disable iff (rst)
    (in_take && out_valid && out_stall) |=> skid_valid)
    else $error("result lost while the output was stalled");

  // A commit always leaves the block in idle mode.
  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && commit_valid) |-> !in_entry)
    else $error("commit reported while still in entry mode");

  // The cursor never passes the last digit position.
  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    state.cursor != 2'd3)
    else $error("cursor beyond the last digit");

endmodule

`default_nettype wire
